@@ rtl/itlb_pkg.sv @@
// shared types and constants for the instruction tlb
// no dependencies; used by itlb_ram and instruction_tlb_translate
package itlb_pkg;

   localparam int WORD_W     = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // match word fields
   localparam int VALID_POS = 0;
   localparam int LRU_LO    = 6;
   localparam int LRU_HI    = 7;

   // translate word fields
   localparam int CI_POS  = 1;
   localparam int SXE_POS = 6;
   localparam int UXE_POS = 7;
   localparam logic [WORD_W-1:0] PPN_MASK = 32'hFFFF_E000;

   typedef enum logic [1:0] {
      CMD_TRANSLATE   = 2'd0,
      CMD_PROBE       = 2'd1,
      CMD_WRITE_MATCH = 2'd2,
      CMD_WRITE_XLATE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_PAGE_FAULT = 2'd1,
      ST_MISS       = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_UNIT_PRESENT = 2'd0,
      REG_IDX_BITS     = 2'd1,
      REG_WAY_COUNT    = 2'd2,
      REG_PAGE_SHIFT   = 2'd3
   } reg_index_type;

endpackage

@@ rtl/instruction_tlb_translate.sv @@
// Set-associative instruction TLB, top level.
// Request channel (req_*): one item per command: translate, probe, or a write of a
//   match word or translate word at a given set and way. The command rides in tuser.
// Response channel (rsp_*): exactly one item per request: physical address and
//   cache-inhibit in tdata, status (ok, page fault, miss) in tuser.
// CSR port (csr_*): APB-style, registers at byte addresses 0, 4, 8, 12:
//   unit present, index width, way count, page shift. Write only while the TLB is idle.
// Pipeline: an accepted request passes the lookup stage register, then the response register.
// Throughput: one item per cycle while rsp_tready stays high. The set is read from per-way
//   RAMs at the accept edge; the next stage compares, builds the response and writes
//   back LRU updates, with the last write forwarded to the following item.
// Reset: loads the CSR reset values and then sweeps the match words of all MAX_SETS
//   sets to zero, one set per cycle; req_tready stays low meanwhile.
//   Translate words are not cleared.
// Stall: when rsp_tready is low the response register holds, the lookup stage
//   holds behind it and req_tready drops; no item is lost or repeated.
// depends on itlb_pkg and itlb_ram
module instruction_tlb_translate #(
   parameter int MAX_SETS = 128,
   parameter int MAX_WAYS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   // csr port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [itlb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [itlb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [itlb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] virtual_address, [32] mmu_enable, [33] supervisor, [40:34] set_index,
   // [42:41] way_select, [74:43] entry_word, [79:75] zero
   input  logic [79:0]                         req_tdata,
   // [1:0] command
   input  logic [1:0]                          req_tuser,
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] physical_address, [32] cache_inhibit, [39:33] zero
   output logic [39:0]                         rsp_tdata,
   // [1:0] status
   output logic [1:0]                          rsp_tuser
);
   import itlb_pkg::*;

   localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

   // ---------------- csr ----------------
   logic       unit_present_ff, unit_present_in;
   logic [2:0] idx_bits_ff, idx_bits_in;
   logic [2:0] way_count_ff, way_count_in;
   logic [4:0] page_shift_ff, page_shift_in;
   logic       csr_wr;
   reg_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      unit_present_in = unit_present_ff;
      idx_bits_in     = idx_bits_ff;
      way_count_in    = way_count_ff;
      page_shift_in   = page_shift_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_UNIT_PRESENT: unit_present_in = csr_pwdata[0];
            REG_IDX_BITS:     idx_bits_in     = csr_pwdata[2:0];
            REG_WAY_COUNT:    way_count_in    = csr_pwdata[2:0];
            REG_PAGE_SHIFT:   page_shift_in   = csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_UNIT_PRESENT: csr_prdata = {31'd0, unit_present_ff};
         REG_IDX_BITS:     csr_prdata = {29'd0, idx_bits_ff};
         REG_WAY_COUNT:    csr_prdata = {29'd0, way_count_ff};
         REG_PAGE_SHIFT:   csr_prdata = {27'd0, page_shift_ff};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_present_ff <= 1'b0;
         idx_bits_ff     <= 3'd0;
         way_count_ff    <= 3'd1;
         page_shift_ff   <= 5'd13;
      end else begin
         unit_present_ff <= unit_present_in;
         idx_bits_ff     <= idx_bits_in;
         way_count_ff    <= way_count_in;
         page_shift_ff   <= page_shift_in;
      end
   end

   // ---------------- request unpack and set index ----------------
   cmd_type           req_cmd;
   logic [WORD_W-1:0] req_va;
   logic [WORD_W-1:0] req_shifted;
   logic [6:0]        idx_mask;
   logic [6:0]        req_set7;
   logic              req_fire;

   assign req_cmd     = cmd_type'(req_tuser);
   assign req_va      = req_tdata[31:0];
   assign req_shifted = req_va >> page_shift_ff;
   assign idx_mask    = 7'((8'd1 << idx_bits_ff) - 8'd1);
   assign req_set7    = req_shifted[6:0] & idx_mask;
   assign req_fire    = req_tvalid && req_tready;

   // ---------------- lookup stage registers ----------------
   logic              s1_valid_ff, s1_valid_in;
   cmd_type           s1_cmd_ff, s1_cmd_in;
   logic [WORD_W-1:0] s1_va_ff, s1_va_in;
   logic              s1_en_ff, s1_en_in;
   logic              s1_sup_ff, s1_sup_in;
   logic [6:0]        s1_set7_ff, s1_set7_in;
   logic [6:0]        s1_wset_ff, s1_wset_in;
   logic [1:0]        s1_way_ff, s1_way_in;
   logic [WORD_W-1:0] s1_word_ff, s1_word_in;
   logic              s1_fire;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_pa_ff, rsp_pa_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic              rsp_ci_ff, rsp_ci_in;

   // reset sweep of the match words
   logic             clearing_ff, clearing_in;
   logic [SET_W-1:0] clr_cnt_ff, clr_cnt_in;

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clearing_ff && (!s1_valid_ff || s1_fire);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_cmd_in   = s1_cmd_ff;
      s1_va_in    = s1_va_ff;
      s1_en_in    = s1_en_ff;
      s1_sup_in   = s1_sup_ff;
      s1_set7_in  = s1_set7_ff;
      s1_wset_in  = s1_wset_ff;
      s1_way_in   = s1_way_ff;
      s1_word_in  = s1_word_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_cmd_in   = req_cmd;
         s1_va_in    = req_va;
         s1_en_in    = req_tdata[32];
         s1_sup_in   = req_tdata[33];
         s1_set7_in  = req_set7;
         s1_wset_in  = req_tdata[40:34];
         s1_way_in   = req_tdata[42:41];
         s1_word_in  = req_tdata[74:43];
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------- way memories ----------------
   logic [WORD_W-1:0] m_rd [MAX_WAYS];
   logic [WORD_W-1:0] t_rd [MAX_WAYS];
   logic [WORD_W-1:0] m_wdata [MAX_WAYS];
   logic              m_we [MAX_WAYS];
   logic              t_we [MAX_WAYS];
   logic [SET_W-1:0]  m_waddr;
   logic [SET_W-1:0]  wr_addr;

   for (genvar w = 0; w < MAX_WAYS; w++) begin : g_way
      itlb_ram #(.DEPTH(MAX_SETS), .ADDR_W(SET_W)) u_match (
         .clock   (clock),
         .wr_en   (m_we[w]),
         .wr_addr (m_waddr),
         .wr_data (m_wdata[w]),
         .rd_en   (req_fire),
         .rd_addr (req_set7[SET_W-1:0]),
         .rd_data (m_rd[w])
      );
      itlb_ram #(.DEPTH(MAX_SETS), .ADDR_W(SET_W)) u_xlate (
         .clock   (clock),
         .wr_en   (t_we[w]),
         .wr_addr (wr_addr),
         .wr_data (s1_word_ff),
         .rd_en   (req_fire),
         .rd_addr (req_set7[SET_W-1:0]),
         .rd_data (t_rd[w])
      );
   end

   // last write made at the edge the current item read its set
   logic              fwd_we_m_ff [MAX_WAYS];
   logic              fwd_we_m_in [MAX_WAYS];
   logic              fwd_we_t_ff [MAX_WAYS];
   logic              fwd_we_t_in [MAX_WAYS];
   logic [WORD_W-1:0] fwd_m_ff [MAX_WAYS];
   logic [WORD_W-1:0] fwd_m_in [MAX_WAYS];
   logic [WORD_W-1:0] fwd_t_ff, fwd_t_in;
   logic [SET_W-1:0]  fwd_addr_ff, fwd_addr_in;

   // ---------------- lookup logic ----------------
   logic [2:0]        ways_n;
   logic              set_ok;
   logic [SET_W-1:0]  s1_addr;
   logic [5:0]        total;
   logic [WORD_W-1:0] tag_mask;
   logic [WORD_W-1:0] off_mask;
   logic [WORD_W-1:0] m_cur [MAX_WAYS];
   logic [WORD_W-1:0] t_cur [MAX_WAYS];
   logic [WORD_W-1:0] lru_new [MAX_WAYS];
   logic [MAX_WAYS-1:0] hit_vec;
   logic [MAX_WAYS-1:0] hit_first;
   logic              hit_any;
   logic [WAY_W-1:0]  hit_way;
   logic [WORD_W-1:0] tr;
   logic [WORD_W-1:0] pa;
   logic              perm;
   logic [1:0]        reload;
   logic              is_write;
   logic              wr_ok;
   logic              passthru;
   logic              lookup;

   assign ways_n   = (int'(way_count_ff) > MAX_WAYS) ? 3'(MAX_WAYS) : way_count_ff;
   assign set_ok   = int'(s1_set7_ff) < MAX_SETS;
   assign s1_addr  = s1_set7_ff[SET_W-1:0];
   assign total    = {1'b0, page_shift_ff} + {3'd0, idx_bits_ff};
   assign tag_mask = total[5] ? '0 : ({WORD_W{1'b1}} << total[4:0]);
   assign off_mask = ~({WORD_W{1'b1}} << page_shift_ff);
   assign reload   = (idx_bits_ff == 3'd0) ? 2'd0 : (idx_bits_ff == 3'd1) ? 2'd1 : 2'd3;
   assign is_write = (s1_cmd_ff == CMD_WRITE_MATCH) || (s1_cmd_ff == CMD_WRITE_XLATE);
   assign wr_ok    = (int'(s1_wset_ff) < MAX_SETS) && (int'(s1_way_ff) < MAX_WAYS);
   assign passthru = !s1_en_ff || !unit_present_ff;
   assign lookup   = !is_write && !passthru;
   assign wr_addr  = s1_wset_ff[SET_W-1:0];

   always_comb begin
      hit_any   = 1'b0;
      hit_way   = '0;
      hit_first = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         m_cur[w] = (fwd_we_m_ff[w] && fwd_addr_ff == s1_addr) ? fwd_m_ff[w] : m_rd[w];
         t_cur[w] = (fwd_we_t_ff[w] && fwd_addr_ff == s1_addr) ? fwd_t_ff : t_rd[w];
         hit_vec[w] = (w < int'(ways_n)) && set_ok && m_cur[w][VALID_POS] &&
                      (((m_cur[w] ^ s1_va_ff) & tag_mask) == '0);
      end
      // lowest hitting way wins
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         hit_first[w] = hit_any && (int'(hit_way) == w);
      end
   end

   assign tr   = t_cur[hit_way];
   assign perm = s1_sup_ff ? tr[SXE_POS] : tr[UXE_POS];
   assign pa   = (tr & PPN_MASK) | (s1_va_ff & off_mask);

   // lru aging of the searched ways, reload on the hit way
   always_comb begin
      logic [1:0] lru;
      logic [1:0] dec;
      for (int w = 0; w < MAX_WAYS; w++) begin
         lru = m_cur[w][LRU_HI:LRU_LO];
         dec = (lru != 2'd0) ? lru - 2'd1 : 2'd0;
         lru_new[w] = m_cur[w];
         lru_new[w][LRU_HI:LRU_LO] = dec | (hit_first[w] ? reload : 2'd0);
      end
   end

   always_comb begin
      m_waddr = is_write ? wr_addr : s1_addr;
      for (int w = 0; w < MAX_WAYS; w++) begin
         m_we[w] = s1_fire &&
                   ((s1_cmd_ff == CMD_WRITE_MATCH && wr_ok && int'(s1_way_ff) == w) ||
                    (s1_cmd_ff == CMD_TRANSLATE && lookup && hit_any && w < int'(ways_n)));
         m_wdata[w] = (s1_cmd_ff == CMD_WRITE_MATCH) ? s1_word_ff : lru_new[w];
         t_we[w] = s1_fire && s1_cmd_ff == CMD_WRITE_XLATE && wr_ok &&
                   int'(s1_way_ff) == w;
      end
      if (clearing_ff) begin
         m_waddr = clr_cnt_ff;
         for (int w = 0; w < MAX_WAYS; w++) begin
            m_we[w]    = 1'b1;
            m_wdata[w] = '0;
         end
      end
   end

   always_comb begin
      fwd_addr_in = fwd_addr_ff;
      fwd_t_in    = fwd_t_ff;
      for (int w = 0; w < MAX_WAYS; w++) begin
         fwd_we_m_in[w] = fwd_we_m_ff[w];
         fwd_we_t_in[w] = fwd_we_t_ff[w];
         fwd_m_in[w]    = fwd_m_ff[w];
      end
      if (req_fire) begin
         fwd_addr_in = m_waddr;
         fwd_t_in    = s1_word_ff;
         for (int w = 0; w < MAX_WAYS; w++) begin
            fwd_we_m_in[w] = m_we[w];
            fwd_we_t_in[w] = t_we[w];
            fwd_m_in[w]    = m_wdata[w];
         end
      end
   end

   // ---------------- response ----------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_pa_in     = rsp_pa_ff;
      rsp_status_in = rsp_status_ff;
      rsp_ci_in     = rsp_ci_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
         if (is_write) begin
            rsp_pa_in     = '0;
            rsp_status_in = ST_OK;
            rsp_ci_in     = 1'b0;
         end else if (passthru) begin
            rsp_pa_in     = s1_va_ff;
            rsp_status_in = ST_OK;
            rsp_ci_in     = s1_va_ff[WORD_W-1];
         end else if (!hit_any) begin
            rsp_pa_in     = '0;
            rsp_status_in = ST_MISS;
            rsp_ci_in     = 1'b0;
         end else if (s1_cmd_ff == CMD_PROBE && !perm) begin
            rsp_pa_in     = '0;
            rsp_status_in = ST_PAGE_FAULT;
            rsp_ci_in     = 1'b0;
         end else begin
            // translate fault still reports the address and ci
            rsp_pa_in     = pa;
            rsp_status_in = perm ? ST_OK : ST_PAGE_FAULT;
            rsp_ci_in     = tr[CI_POS];
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ci_ff, rsp_pa_ff};
   assign rsp_tuser  = rsp_status_ff;

   // ---------------- clear sweep ----------------
   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == SET_W'(MAX_SETS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         for (int w = 0; w < MAX_WAYS; w++) begin
            fwd_we_m_ff[w] <= 1'b0;
            fwd_we_t_ff[w] <= 1'b0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         clearing_ff  <= clearing_in;
         clr_cnt_ff   <= clr_cnt_in;
         for (int w = 0; w < MAX_WAYS; w++) begin
            fwd_we_m_ff[w] <= fwd_we_m_in[w];
            fwd_we_t_ff[w] <= fwd_we_t_in[w];
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff     <= s1_cmd_in;
      s1_va_ff      <= s1_va_in;
      s1_en_ff      <= s1_en_in;
      s1_sup_ff     <= s1_sup_in;
      s1_set7_ff    <= s1_set7_in;
      s1_wset_ff    <= s1_wset_in;
      s1_way_ff     <= s1_way_in;
      s1_word_ff    <= s1_word_in;
      rsp_pa_ff     <= rsp_pa_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ci_ff     <= rsp_ci_in;
      fwd_addr_ff   <= fwd_addr_in;
      fwd_t_ff      <= fwd_t_in;
      for (int w = 0; w < MAX_WAYS; w++) begin
         fwd_m_ff[w] <= fwd_m_in[w];
      end
   end

`ifndef NO_ASSERTIONS
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_tready)
      else $error("item accepted during match word sweep");

   a_single_hit_way: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_first))
      else $error("more than one way selected as hit");

   a_write_result_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && is_write) |=> (rsp_pa_ff == '0 && rsp_status_ff == ST_OK && !rsp_ci_ff))
      else $error("write command gave a nonzero result");

   a_miss_result: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && lookup && !hit_any) |=> (rsp_pa_ff == '0 && rsp_status_ff == ST_MISS))
      else $error("miss did not report zero address and miss status");
`endif

endmodule

@@ rtl/itlb_ram.sv @@
// one way of tlb storage: single write port, registered read port
// depends on itlb_pkg
module itlb_ram #(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [itlb_pkg::WORD_W-1:0]   wr_data,
   input  logic                          rd_en,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [itlb_pkg::WORD_W-1:0]   rd_data
);
   import itlb_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
